// ===== hw/rtl/adcba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcba_pkg: shared types and constants of the ADC code block averager
// Field widths, scaling constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package adcba_pkg;

  // Field and state widths
  localparam int CODE_W = 12;  // converter code
  localparam int MV_W   = 15;  // millivolt value, signed
  localparam int CNT_W  = 8;   // sample counter and block length
  localparam int SUM_W  = 23;  // running sum, signed
  localparam int MAG_W  = SUM_W - 1;  // magnitude of the running sum

  // Scaling: mv = code * FULL_SCALE_MV / 2**SPAN_SHIFT, truncated toward zero
  localparam int FULL_SCALE_MV = 20000;
  localparam int SPAN_SHIFT    = 12;
  localparam int PROD_W        = 27;  // holds +/-2048 * 20000 signed

  // Block length limits and reset value
  localparam int CNT_MAX       = (2 ** CNT_W) - 1;
  localparam int BLOCK_LEN_RST = 100;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for a sample beat
    ST_ACC,   // add scaled sample to running sum
    ST_CHK,   // check for end of block, start divide
    ST_DIV,   // divider busy
    ST_FIX    // apply sign, load output register
  } adcba_state_e;

endpackage : adcba_pkg
`default_nettype wire

// ===== hw/rtl/adcba_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcba_scale: converter code to millivolts
// Registers code * 20000, then divides by 4096 toward zero (bias + shift).
// ----------------------------------------------------------------------------
module adcba_scale (
  input  wire logic                               clk_i,
  input  wire logic                               load_i,
  input  wire logic [adcba_pkg::CODE_W-1:0]       code_i,
  output logic signed [adcba_pkg::MV_W-1:0]       mv_o
);
  import adcba_pkg::*;

  logic signed [PROD_W-1:0] code_ext;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] bias;
  logic signed [PROD_W-1:0] adj;

  // Sign-extend from bit 11 and multiply by full scale
  assign code_ext = {{(PROD_W - CODE_W){code_i[CODE_W-1]}}, code_i};
  assign prod_d   = code_ext * PROD_W'(FULL_SCALE_MV);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // Truncate toward zero: negative products get a bias of 2**SPAN_SHIFT-1
  assign bias = prod_q[PROD_W-1] ? PROD_W'((2 ** SPAN_SHIFT) - 1) : '0;
  assign adj  = prod_q + bias;
  assign mv_o = adj[SPAN_SHIFT +: MV_W];

endmodule : adcba_scale
`default_nettype wire

// ===== hw/rtl/adcba_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcba_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module adcba_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [adcba_pkg::MAG_W-1:0]   dividend_i,
  input  wire logic [adcba_pkg::CNT_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [adcba_pkg::MAG_W-1:0]        quotient_o
);
  import adcba_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [MAG_W-1:0]  quo_q;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Shared subtract and compare
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top, quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : adcba_div
`default_nettype wire

// ===== hw/rtl/adc_code_block_averager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_code_block_averager: boxcar block average of ADC codes in millivolts
// Scales each 12-bit code to mV, sums a block, emits the block average.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid_i/sample_ready_o, sample_code_i): one beat
//   per converter code. Ready is high only while the sequencer is idle.
//   average channel (average_valid_o/average_ready_i, average_mv_o): one beat
//   per completed block, held in an output register until taken.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_data_i): block length, always
//   ready; write it only while the block is idle. 0 acts as 1.
// Timing:
//   A sample that does not end a block passes through accept, accumulate and
//   check. A sample that ends a block then runs the bit-serial divider (one
//   quotient bit per cycle for the 22-bit sum magnitude), raises its done
//   strobe and loads the output register once no earlier average is waiting.
//   The average appears the cycle after that load.
// Reset: sum and count clear, block length returns to 100, no average valid.
// Stall: new samples are taken while an average waits; a further block end
//   holds in the final sign step until the waiting average is taken.
// ----------------------------------------------------------------------------
module adc_code_block_averager #(
  parameter int MAX_BLOCK_LENGTH = 255
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // sample channel
  input  wire logic                             sample_valid_i,
  output logic                                  sample_ready_o,
  input  wire logic [adcba_pkg::CODE_W-1:0]     sample_code_i,
  // average channel
  output logic                                  average_valid_o,
  input  wire logic                             average_ready_i,
  output logic signed [adcba_pkg::MV_W-1:0]     average_mv_o,
  // configuration channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [adcba_pkg::CNT_W-1:0]      cfg_data_i
);
  import adcba_pkg::*;

  localparam int CapLen = (MAX_BLOCK_LENGTH > CNT_MAX) ? CNT_MAX : MAX_BLOCK_LENGTH;

  adcba_state_e state_q, state_d;

  logic [CNT_W-1:0]        spa_q;
  logic [CNT_W-1:0]        count_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic signed [MV_W-1:0]  out_mv_q;

  logic                    sample_fire;
  logic                    acc_en;
  logic                    chk_en;
  logic                    div_start;
  logic                    out_load;
  logic                    block_end;
  logic [CNT_W-1:0]        blen;
  logic                    div_done;
  logic [MAG_W-1:0]        quotient;
  logic [MAG_W-1:0]        sum_mag;
  logic signed [MV_W-1:0]  mv;
  logic [MV_W-1:0]         q_trunc;

  assign sample_fire = sample_valid_i && sample_ready_o;

  // Effective block length: zero acts as one, capped at the bound
  always_comb begin
    blen = spa_q;
    if (blen == '0) begin
      blen = CNT_W'(1);
    end
    if (blen > CNT_W'(CapLen)) begin
      blen = CNT_W'(CapLen);
    end
  end

  assign block_end = (count_q != '0) && (count_q >= blen);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_fire) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = block_end ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_FIX;
      end
      ST_FIX: begin
        if (!out_valid_q || average_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    sample_ready_o = 1'b0;
    acc_en         = 1'b0;
    chk_en         = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      ST_IDLE: sample_ready_o = 1'b1;
      ST_ACC:  acc_en = 1'b1;
      ST_CHK: begin
        chk_en    = 1'b1;
        div_start = block_end;
      end
      ST_DIV: ;
      ST_FIX:  out_load = !out_valid_q || average_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Block length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q <= CNT_W'(BLOCK_LEN_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      spa_q <= cfg_data_i;
    end
  end

  // Code to millivolts
  adcba_scale u_scale (
    .clk_i  (clk_i),
    .load_i (sample_fire),
    .code_i (sample_code_i),
    .mv_o   (mv)
  );

  // Running sum and sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (out_load) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (acc_en) begin
      sum_q   <= sum_q + {{(SUM_W - MV_W){mv[MV_W-1]}}, mv};
      count_q <= count_q + 1'b1;
    end
  end

  // Sign of the block sum, kept for the quotient
  assign sum_mag = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : sum_q[MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (chk_en) begin
      neg_q <= sum_q[SUM_W-1];
    end
  end

  // Divide magnitude by the samples summed
  adcba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register
  assign q_trunc = quotient[MV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (average_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mv_q <= neg_q ? -$signed(q_trunc) : $signed(q_trunc);
    end
  end

  assign average_valid_o = out_valid_q;
  assign average_mv_o    = out_mv_q;

endmodule : adc_code_block_averager
`default_nettype wire

// ===== hw/rtl/adcba_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcba_checker: port-level checks for the ADC code block averager
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module adcba_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             sample_valid_i,
  input  wire logic                             sample_ready_o,
  input  wire logic                             average_valid_o,
  input  wire logic                             average_ready_i,
  input  wire logic signed [adcba_pkg::MV_W-1:0] average_mv_o
);
  import adcba_pkg::*;

  // A stalled average beat holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    average_valid_o && !average_ready_i |=> average_valid_o && $stable(average_mv_o))
    else $error("average beat dropped or changed while stalled");

  // One sample at a time: ready drops after each accepted sample beat
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> !sample_ready_o)
    else $error("sample accepted while previous one still in work");

  // A new average only follows a busy cycle of the sequencer
  a_avg_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(average_valid_o) |-> $past(!sample_ready_o))
    else $error("average appeared without sequencer work");

  // Average stays within the converter's millivolt span
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    average_valid_o |-> (average_mv_o >= -15'sd10000) && (average_mv_o <= 15'sd9995))
    else $error("average out of range");

endmodule : adcba_checker

bind adc_code_block_averager adcba_checker u_adcba_checker (.*);
`default_nettype wire
